[rtl/vertex_dedup_index_builder_top_macros.svh]
// Assertion helpers shared by the RTL files of the vertex index builder.
`ifndef VERTEX_DEDUP_INDEX_BUILDER_TOP_MACROS_SVH
`define VERTEX_DEDUP_INDEX_BUILDER_TOP_MACROS_SVH

// The condition on the left implies the property in the same cycle.
`define VDDIB_ASSERT_IMPLY(name, clock, reset, cond, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("vddib: same-cycle check failed");

// The condition on the left implies the property in the next cycle.
`define VDDIB_ASSERT_NEXT(name, clock, reset, cond, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error("vddib: next-cycle check failed");

`endif

[rtl/vddib_pkg.sv]
`default_nettype none

package vddib_pkg;

  typedef struct packed {
    logic               mesh_start;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]         vertex_index;
    logic [1:0]         status;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } out_beat_t;

  // One stored corner; equality is a plain bit compare of all five words.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] u;
    logic [31:0] v;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } box_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } cell_ctl_t;

  typedef struct packed {
    logic clear;
    logic grow;
  } box_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  localparam logic [1:0] STATUS_REUSED = 2'd0;
  localparam logic [1:0] STATUS_ADDED  = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

endpackage

`default_nettype wire

[rtl/vddib_cell.sv]
`default_nettype none

// One table slot. The occupied flags of all cells form a fill thermometer:
// a cell takes an insert only when its left neighbor is occupied and it is not.
module vddib_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vddib_pkg::cell_ctl_t ctl,
  input  wire logic                prev_occ,
  input  wire vddib_pkg::vertex_t  query,
  output logic                     occ,
  output logic                     hit
);

  vddib_pkg::vertex_t entry;
  logic               take;

  assign take = ctl.insert & prev_occ & ~occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.clear) begin
      occ <= 1'b0;
    end else if (take) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry <= query;
    end
    hit <= occ & (entry == query);
  end

endmodule

`default_nettype wire

[rtl/vddib_box.sv]
`default_nettype none

// Axis-aligned bounding box of the inserted corners.
module vddib_box (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vddib_pkg::box_ctl_t ctl,
  input  wire vddib_pkg::vertex_t  point,
  output vddib_pkg::box_t          bounds_next
);

  vddib_pkg::box_t    bounds;
  vddib_pkg::box_t    grown;
  logic               box_valid;
  logic               box_valid_next;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;

  assign px = $signed(point.x);
  assign py = $signed(point.y);
  assign pz = $signed(point.z);

  always_comb begin
    if (!box_valid) begin
      grown = '{px, py, pz, px, py, pz};
    end else begin
      grown.min_x = (px < bounds.min_x) ? px : bounds.min_x;
      grown.min_y = (py < bounds.min_y) ? py : bounds.min_y;
      grown.min_z = (pz < bounds.min_z) ? pz : bounds.min_z;
      grown.max_x = (bounds.max_x < px) ? px : bounds.max_x;
      grown.max_y = (bounds.max_y < py) ? py : bounds.max_y;
      grown.max_z = (bounds.max_z < pz) ? pz : bounds.max_z;
    end
  end

  always_comb begin
    if (ctl.clear) begin
      bounds_next    = '0;
      box_valid_next = 1'b0;
    end else if (ctl.grow) begin
      bounds_next    = grown;
      box_valid_next = 1'b1;
    end else begin
      bounds_next    = bounds;
      box_valid_next = box_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds    <= '0;
      box_valid <= 1'b0;
    end else begin
      bounds    <= bounds_next;
      box_valid <= box_valid_next;
    end
  end

endmodule

`default_nettype wire

[rtl/vertex_dedup_index_builder_top.sv]
// Vertex deduplication index builder: one triangle corner in, one index out.
// Input channel in_valid / in_stall / in_data carries a corner (mesh_start,
// position and texture coordinates, signed Q16.16). Output channel
// out_valid / out_stall / out_data returns the table index, a status code
// (reused, added, table full) and the bounding box after that corner.
// A beat moves when valid is high and stall is low at a rising clock edge.
// uv_enable is written through cfg_wen / cfg_wdata; the user must write it
// only while the block is idle, which the block does not enforce. It takes
// a new corner only after the last result is loaded. Each table cell
// compares its entry against the corner in parallel and registers its hit;
// then a new corner goes into the next free cell, if any, and the box grows.
// Synchronous reset empties the table and the box and clears uv_enable.
// While out_stall holds a finished result, the next corner may still be
// taken and compared; its decision waits until the output register frees.
`default_nettype none
`include "vertex_dedup_index_builder_top_macros.svh"

module vertex_dedup_index_builder_top #(
  parameter int unsigned MAX_VERTICES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vddib_pkg::in_beat_t in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vddib_pkg::out_beat_t     out_data,
  input  wire logic                cfg_wen,
  input  wire logic                cfg_wdata
);

  localparam int unsigned IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  vddib_pkg::state_t    state;
  vddib_pkg::state_t    state_next;
  vddib_pkg::cell_ctl_t cell_ctl;
  vddib_pkg::box_ctl_t  box_ctl;
  vddib_pkg::vertex_t   query;
  vddib_pkg::box_t      box_next;
  vddib_pkg::out_beat_t out_next;

  logic                    uv_enable;
  logic [CW-1:0]           count;
  logic [MAX_VERTICES-1:0] occ;
  logic [MAX_VERTICES-1:0] hit;
  logic [IW-1:0]           hit_idx;
  logic [IW-1:0]           sel_idx;
  logic [IW+7:0]           idx_wide;
  logic                    found;
  logic                    full;
  logic                    ins_ok;
  logic                    out_free;
  logic                    out_load;
  logic                    in_take;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      uv_enable <= 1'b0;
    end else if (cfg_wen) begin
      uv_enable <= cfg_wdata;
    end
  end

  assign in_take = in_valid & ~in_stall;

  // The corner is held for the whole compare and decision. Texture words are
  // forced to zero when matching ignores them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      query.x <= in_data.pos_x;
      query.y <= in_data.pos_y;
      query.z <= in_data.pos_z;
      query.u <= uv_enable ? in_data.tex_u : 32'd0;
      query.v <= uv_enable ? in_data.tex_v : 32'd0;
    end
  end

  // Row of table cells; each one passes its occupied flag to the right.
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    logic prev_occ;
    if (g == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_rest
      assign prev_occ = occ[g-1];
    end
    vddib_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl),
      .prev_occ (prev_occ),
      .query    (query),
      .occ      (occ[g]),
      .hit      (hit[g])
    );
  end

  vddib_box u_box (
    .clk         (clk),
    .rst         (rst),
    .ctl         (box_ctl),
    .point       (query),
    .bounds_next (box_next)
  );

  // Entries are distinct, so at most one cell hits and an OR encode suffices.
  always_comb begin
    hit_idx = '0;
    found   = 1'b0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | IW'(i);
        found   = 1'b1;
      end
    end
  end

  assign full     = (count == CW'(MAX_VERTICES));
  assign ins_ok   = ~found & ~full;
  assign out_free = ~out_valid | ~out_stall;

  // Entry count, kept in binary beside the cells' fill thermometer.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cell_ctl.clear) begin
      count <= '0;
    end else if (cell_ctl.insert) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vddib_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vddib_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = vddib_pkg::ST_MATCH;
        end
      end
      vddib_pkg::ST_MATCH: begin
        state_next = vddib_pkg::ST_UPDATE;
      end
      vddib_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_next = vddib_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vddib_pkg::ST_IDLE;
      end
    endcase
  end

  // Mesh start clears the table and box on the input beat, so the compare
  // that follows already sees the empty mesh.
  always_comb begin
    in_stall = 1'b1;
    cell_ctl = '0;
    box_ctl  = '0;
    out_load = 1'b0;
    case (state)
      vddib_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cell_ctl.clear = in_valid & in_data.mesh_start;
        box_ctl.clear  = in_valid & in_data.mesh_start;
      end
      vddib_pkg::ST_MATCH: begin
        in_stall = 1'b1;
      end
      vddib_pkg::ST_UPDATE: begin
        if (out_free) begin
          out_load        = 1'b1;
          cell_ctl.insert = ins_ok;
          box_ctl.grow    = ins_ok;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Result assembly. Indices wider than eight bits are reported modulo 256.
  always_comb begin
    if (found) begin
      sel_idx = hit_idx;
    end else if (ins_ok) begin
      sel_idx = count[IW-1:0];
    end else begin
      sel_idx = '0;
    end
    idx_wide              = {8'd0, sel_idx};
    out_next.vertex_index = idx_wide[7:0];
    if (found) begin
      out_next.status = vddib_pkg::STATUS_REUSED;
    end else if (ins_ok) begin
      out_next.status = vddib_pkg::STATUS_ADDED;
    end else begin
      out_next.status = vddib_pkg::STATUS_FULL;
    end
    out_next.box_min_x = box_next.min_x;
    out_next.box_min_y = box_next.min_y;
    out_next.box_min_z = box_next.min_z;
    out_next.box_max_x = box_next.max_x;
    out_next.box_max_y = box_next.max_y;
    out_next.box_max_z = box_next.max_z;
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // Stored corners are distinct, so the decision never sees two hits.
  `VDDIB_ASSERT_IMPLY(a_single_hit, clk, rst, state == vddib_pkg::ST_UPDATE, $onehot0(hit))
  // The binary count and the cells' fill thermometer agree.
  `VDDIB_ASSERT_IMPLY(a_count_matches_cells, clk, rst, 1'b1, $countones(occ) == int'(count))
  // No insert is made into a full table.
  `VDDIB_ASSERT_IMPLY(a_no_insert_when_full, clk, rst, cell_ctl.insert, !full)
  // An insert grows the count by exactly one.
  `VDDIB_ASSERT_NEXT(a_insert_counts, clk, rst, cell_ctl.insert, count == $past(count) + CW'(1))

endmodule

`default_nettype wire

[test/vertex_dedup_index_builder_checker.sv]
`timescale 1ns / 100ps

module vertex_dedup_index_builder_checker #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  vddib_pkg::in_beat_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  vddib_pkg::out_beat_t out_data,
  input  logic                 cfg_wen,
  input  logic                 cfg_wdata,
  output int                   failures,
  output int                   outstanding,
  output int                   reused_count,
  output int                   added_count,
  output int                   full_count
);

  // Shadow copy of the mesh being built: distinct corners, bounding box, uv mode.
  vddib_pkg::vertex_t   mesh_vertices [TABLE_DEPTH];
  int unsigned          mesh_count;
  vddib_pkg::box_t      mesh_box;
  logic                 mesh_box_set;
  logic                 uv_used;
  vddib_pkg::out_beat_t indices_due [$];
  int                   results_seen;

  initial begin
    failures     = 0;
    outstanding  = 0;
    reused_count = 0;
    added_count  = 0;
    full_count   = 0;
    results_seen = 0;
  end

  function automatic vddib_pkg::out_beat_t dedup_corner(input vddib_pkg::in_beat_t c);
    vddib_pkg::vertex_t   key;
    vddib_pkg::out_beat_t r;
    int                   hit;
    int                   i;
    hit = -1;
    r   = '0;
    if (c.mesh_start) begin
      mesh_count   = 0;
      mesh_box     = '0;
      mesh_box_set = 1'b0;
    end
    key.x = c.pos_x;
    key.y = c.pos_y;
    key.z = c.pos_z;
    key.u = uv_used ? c.tex_u : 32'd0;
    key.v = uv_used ? c.tex_v : 32'd0;
    for (i = 0; i < int'(mesh_count); i++)
      if (hit < 0 && mesh_vertices[i] == key) hit = i;
    if (hit >= 0) begin
      r.vertex_index = hit[7:0];
      r.status       = vddib_pkg::STATUS_REUSED;
    end else if (mesh_count < TABLE_DEPTH) begin
      r.vertex_index             = mesh_count[7:0];
      r.status                   = vddib_pkg::STATUS_ADDED;
      mesh_vertices[mesh_count]  = key;
      mesh_count++;
      if (!mesh_box_set) begin
        mesh_box.min_x = key.x;
        mesh_box.min_y = key.y;
        mesh_box.min_z = key.z;
        mesh_box.max_x = key.x;
        mesh_box.max_y = key.y;
        mesh_box.max_z = key.z;
        mesh_box_set   = 1'b1;
      end else begin
        if ($signed(key.x) < mesh_box.min_x) mesh_box.min_x = key.x;
        if ($signed(key.y) < mesh_box.min_y) mesh_box.min_y = key.y;
        if ($signed(key.z) < mesh_box.min_z) mesh_box.min_z = key.z;
        if ($signed(key.x) > mesh_box.max_x) mesh_box.max_x = key.x;
        if ($signed(key.y) > mesh_box.max_y) mesh_box.max_y = key.y;
        if ($signed(key.z) > mesh_box.max_z) mesh_box.max_z = key.z;
      end
    end else begin
      r.vertex_index = 8'd0;
      r.status       = vddib_pkg::STATUS_FULL;
    end
    // An empty box is all zero, which is what the cleared shadow holds.
    r.box_min_x = mesh_box.min_x;
    r.box_min_y = mesh_box.min_y;
    r.box_min_z = mesh_box.min_z;
    r.box_max_x = mesh_box.max_x;
    r.box_max_y = mesh_box.max_y;
    r.box_max_z = mesh_box.max_z;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_failure($sformatf("mismatch on result %0d: %s is %h, expected %h",
                             results_seen, what, got, want));
  endtask

  always @(posedge clk) begin : watch
    vddib_pkg::out_beat_t want;
    if (rst) begin
      mesh_count   = 0;
      mesh_box     = '0;
      mesh_box_set = 1'b0;
      uv_used      = 1'b0;
      indices_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_wen) uv_used = cfg_wdata;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (indices_due.size() == 0) begin
          note_failure($sformatf("result %0d arrived with no corner waiting: %h",
                                 results_seen, out_data));
        end else begin
          want = indices_due.pop_front();
          check_field("vertex_index", out_data.vertex_index, want.vertex_index);
          check_field("status", out_data.status, want.status);
          check_field("box_min_x", out_data.box_min_x, want.box_min_x);
          check_field("box_min_y", out_data.box_min_y, want.box_min_y);
          check_field("box_min_z", out_data.box_min_z, want.box_min_z);
          check_field("box_max_x", out_data.box_max_x, want.box_max_x);
          check_field("box_max_y", out_data.box_max_y, want.box_max_y);
          check_field("box_max_z", out_data.box_max_z, want.box_max_z);
        end
      end
      if (in_valid && !in_stall) begin
        want = dedup_corner(in_data);
        indices_due.insert(indices_due.size(), want);
        case (want.status)
          vddib_pkg::STATUS_REUSED: reused_count++;
          vddib_pkg::STATUS_ADDED:  added_count++;
          default:                  full_count++;
        endcase
      end
      outstanding <= indices_due.size();
    end
  end

endmodule

[test/vertex_dedup_index_builder_top_tb.sv]
`timescale 1ns / 100ps

module vertex_dedup_index_builder_top_tb;

  localparam int unsigned TABLE_DEPTH = 256;

  // Handy Q16.16 words: the signed extremes and the value one.
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  vddib_pkg::in_beat_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  vddib_pkg::out_beat_t out_data;
  logic                 cfg_wen;
  logic                 cfg_wdata;

  int failures;
  int outstanding;
  int reused_count;
  int added_count;
  int full_count;

  // Sender bookkeeping: beats left in the current burst, corners accepted,
  // the uv_enable value last written, and the corners of the current mesh
  // that later beats may repeat.
  int                  burst_left;
  int                  corners_sent;
  int                  uv_writes;
  logic                uv_now;
  vddib_pkg::in_beat_t mesh_pool [$];

  vertex_dedup_index_builder_top #(
    .MAX_VERTICES(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  // The checker sits beside the block, watches both channels and the
  // register port, and predicts every result on its own.
  vertex_dedup_index_builder_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) index_watch (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .failures    (failures),
    .outstanding (outstanding),
    .reused_count(reused_count),
    .added_count (added_count),
    .full_count  (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop. Even if every corner sat out the longest sender gap and a
  // full receiver hold on top of its time in the block, the run would
  // need well under a fifth of this.
  initial begin : watchdog
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

  // The receiver cycles through segments of its own: free running, light
  // and heavy random stall, a toggling stall, and a long hold. The hold is
  // counted out cycle by cycle here while the sender keeps offering beats,
  // so the block fills up and has to stall its input. The fourth segment is
  // always a hold so that at least one is sure to happen.
  initial begin : receiver
    int mode;
    int span;
    int segment;
    out_stall = 1'b0;
    segment   = 0;
    @(negedge rst);
    forever begin
      segment++;
      mode = (segment == 4) ? 6 : $urandom_range(0, 7);
      span = (mode == 6) ? $urandom_range(50, 90) : $urandom_range(20, 80);
      repeat (span) begin
        case (mode)
          0, 1:    out_stall <= 1'b0;
          2, 3:    out_stall <= ($urandom_range(0, 3) == 0);
          4, 5:    out_stall <= ($urandom_range(0, 9) < 7);
          6:       out_stall <= 1'b1;
          default: out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic vddib_pkg::in_beat_t make_corner(input logic start,
                                                      input logic [31:0] x,
                                                      input logic [31:0] y,
                                                      input logic [31:0] z,
                                                      input logic [31:0] u,
                                                      input logic [31:0] v);
    vddib_pkg::in_beat_t c;
    c.mesh_start = start;
    c.pos_x      = x;
    c.pos_y      = y;
    c.pos_z      = z;
    c.tex_u      = u;
    c.tex_v      = v;
    return c;
  endfunction

  // Mostly full-range words, with a share of small whole numbers so boxes
  // grow in both directions and a share of the signed extremes.
  function automatic logic [31:0] random_word();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 5) return (int'($urandom_range(0, 16)) - 8) <<< 16;
    if (pick < 8) begin
      case ($urandom_range(0, 4))
        0:       return 32'd0;
        1:       return 32'd1;
        2:       return '1;
        3:       return Q_MAX;
        default: return Q_MIN;
      endcase
    end
    return $urandom;
  endfunction

  function automatic vddib_pkg::in_beat_t fresh_corner(input logic start);
    return make_corner(start, random_word(), random_word(), random_word(),
                       random_word(), random_word());
  endfunction

  // Offers one beat and holds it until the block takes it. At the end of a
  // burst valid drops for a random gap; otherwise it stays high so the next
  // corner follows back to back.
  task automatic offer_corner(input vddib_pkg::in_beat_t corner);
    int gap;
    in_valid <= 1'b1;
    in_data  <= corner;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    corners_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
  endtask

  // uv_enable may only change while nothing is in flight.
  task automatic write_uv(input logic uv);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= uv;
    uv_now     = uv;
    uv_writes++;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Random meshes. Most beats are new corners or exact repeats of corners
  // already in the mesh, so the table builds up and hits are common. Some
  // are near misses (one bit flipped) and some are stray mesh starts. A
  // filling pass begins with one long mesh of mostly new corners that runs
  // the table past full.
  task automatic play_meshes(input int budget, input bit filling);
    int                  left;
    int                  mesh_left;
    int                  pick;
    bit                  starting;
    bit                  long_mesh;
    vddib_pkg::in_beat_t c;
    left      = budget;
    long_mesh = filling;
    // A pass that does not fill may carry on the mesh left from before,
    // which exercises a uv_enable change in the middle of a mesh.
    mesh_left = (filling || $urandom_range(0, 1)) ? 0 : $urandom_range(4, 40);
    while (left > 0) begin
      starting = (mesh_left == 0);
      if (starting) begin
        mesh_left = long_mesh ? 340 : $urandom_range(4, 60);
        long_mesh = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (starting) begin
        c = fresh_corner(1'b1);
        mesh_pool.delete();
      end else if (mesh_pool.size() > 0 && pick < (filling ? 8 : 40)) begin
        c = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
        c.mesh_start = 1'b0;
        // With uv off the texture words must not matter, so vary them.
        if (!uv_now) begin
          c.tex_u = random_word();
          c.tex_v = random_word();
        end
      end else if (mesh_pool.size() > 0 && pick < (filling ? 12 : 52)) begin
        c = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
        c.mesh_start = 1'b0;
        c[$urandom_range(0, 159)] ^= 1'b1;
      end else if (!filling && pick < 56) begin
        c = fresh_corner(1'b1);
        mesh_pool.delete();
      end else begin
        c = fresh_corner(1'b0);
      end
      mesh_pool.insert(mesh_pool.size(), c);
      offer_corner(c);
      mesh_left--;
      left--;
    end
  endtask

  initial begin : stimulus
    int phase;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_wen      = 1'b0;
    cfg_wdata    = 1'b0;
    burst_left   = 5;
    corners_sent = 0;
    uv_writes    = 0;
    uv_now       = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed corners, texture coordinates in use first.
    write_uv(1'b1);
    // The first corner of a mesh sets the box; the same corner is reused.
    offer_corner(make_corner(1'b1, 0, 0, 0, 0, 0));
    offer_corner(make_corner(1'b0, 0, 0, 0, 0, 0));
    // Signed extremes on every axis, both ways round.
    offer_corner(make_corner(1'b0, Q_MAX, Q_MIN, '1, Q_MAX, Q_MIN));
    offer_corner(make_corner(1'b0, Q_MIN, Q_MAX, 1, Q_MIN, Q_MAX));
    // Differs only in the lowest bit of v, which counts while uv is on.
    offer_corner(make_corner(1'b0, Q_MAX, Q_MIN, '1, Q_MAX, Q_MIN ^ 32'd1));
    offer_corner(make_corner(1'b0, Q_MIN, Q_MAX, 1, Q_MIN, Q_MAX));
    offer_corner(make_corner(1'b0, '1, '1, '1, '1, '1));
    offer_corner(make_corner(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                             32'h5555_5555, 32'hAAAA_AAAA));
    offer_corner(make_corner(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                             32'hAAAA_AAAA, 32'h5555_5555));
    // A new mesh forgets everything above and starts a fresh box.
    offer_corner(make_corner(1'b1, Q_ONE, -(2 * Q_ONE), 3 * Q_ONE, 7, 9));
    offer_corner(make_corner(1'b0, -Q_ONE, 2 * Q_ONE, 0, 7, 9));
    // Turning uv off mid-mesh: stored entries keep their texture words, so
    // the same position no longer matches, but its uv-free copy then does.
    write_uv(1'b0);
    offer_corner(make_corner(1'b0, Q_ONE, -(2 * Q_ONE), 3 * Q_ONE, 7, 9));
    offer_corner(make_corner(1'b0, Q_ONE, -(2 * Q_ONE), 3 * Q_ONE, 123, 456));
    offer_corner(make_corner(1'b0, -Q_ONE, 2 * Q_ONE, 0, 0, 0));
    offer_corner(make_corner(1'b1, Q_MIN, Q_MIN, Q_MIN, $urandom, $urandom));
    offer_corner(make_corner(1'b0, Q_MAX, Q_MAX, Q_MAX, $urandom, $urandom));
    offer_corner(make_corner(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN));
    // Back-to-back mesh starts, then uv back on against a uv-free entry.
    offer_corner(make_corner(1'b1, 0, 0, 0, Q_MAX, Q_MAX));
    offer_corner(make_corner(1'b1, 0, 0, 0, 0, 0));
    write_uv(1'b1);
    offer_corner(make_corner(1'b0, 0, 0, 0, 0, 0));
    offer_corner(make_corner(1'b0, 0, 0, 0, 0, 1));

    // Random meshes under alternating uv settings; two passes overfill the
    // table, one with uv on and one with it off.
    for (phase = 0; phase < 6; phase++) begin
      write_uv(phase[0]);
      play_meshes((phase == 1 || phase == 4) ? 360 : 290, phase == 1 || phase == 4);
    end

    // Drain: wait for every result, then let the clock run on for anything stray.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d corners over %0d uv_enable writes", corners_sent, uv_writes);
    $display("results: %0d reused, %0d added, %0d table full; %0d field mismatches",
             reused_count, added_count, full_count, failures);
    if (failures == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/vddib_pkg.sv
rtl/vddib_cell.sv
rtl/vddib_box.sv
rtl/vertex_dedup_index_builder_top.sv
test/vertex_dedup_index_builder_checker.sv
test/vertex_dedup_index_builder_top_tb.sv
